### hw/rtl/utf8_nonblank_validator_macros.svh
// Assertion macros used by the utf8_nonblank_validator back end (uv_back).
`ifndef UTF8_NONBLANK_VALIDATOR_MACROS_SVH
`define UTF8_NONBLANK_VALIDATOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define UV_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define UV_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/uv_pkg.sv
// Types, constants and helper functions for the UTF-8 nonblank validator.
package uv_pkg;

   localparam logic [10:0] COUNT_MAX       = 11'd2047;
   localparam logic [10:0] MAX_BYTES_RESET = 11'd1000;
   localparam logic [20:0] CP_MAX          = 21'h10FFFF;
   localparam logic [20:0] SURR_LO         = 21'h00D800;
   localparam logic [20:0] SURR_HI         = 21'h00DFFF;
   localparam logic [20:0] FLOOR_2B        = 21'h000080;
   localparam logic [20:0] FLOOR_3B        = 21'h000800;
   localparam logic [20:0] FLOOR_4B        = 21'h010000;

   localparam logic [1:0] CLS_2B = 2'd0;
   localparam logic [1:0] CLS_3B = 2'd1;
   localparam logic [1:0] CLS_4B = 2'd2;

   typedef enum logic [2:0] {
      KIND_ASCII = 3'd0,
      KIND_LEAD2 = 3'd1,
      KIND_LEAD3 = 3'd2,
      KIND_LEAD4 = 3'd3,
      KIND_CONT  = 3'd4,
      KIND_BAD   = 3'd5
   } kind_type;

   // One classified byte as it travels from front to back.
   typedef struct packed {
      kind_type   kind;
      logic [5:0] bits;
      logic       space;
      logic       last;
   } item_type;

   function automatic logic is_space(input logic [20:0] cp);
      is_space = cp inside {[21'h000009:21'h00000D], 21'h000020, 21'h000085,
                            21'h0000A0, 21'h001680, [21'h002000:21'h00200A],
                            21'h002028, 21'h002029, 21'h00202F, 21'h00205F,
                            21'h003000};
   endfunction

   function automatic logic [20:0] floor_of(input logic [1:0] cls);
      case (cls)
         CLS_2B:  floor_of = FLOOR_2B;
         CLS_3B:  floor_of = FLOOR_3B;
         default: floor_of = FLOOR_4B;
      endcase
   endfunction

endpackage

### hw/rtl/utf8_nonblank_validator.sv
// Top level of the UTF-8 nonblank validator: front classifier, queue, back decoder.
//
// Checks a text delivered one byte per transfer, with req_last on the final
// byte, and returns one verdict per text: strict UTF-8, not all whitespace,
// length within csr_wdata-programmed max_bytes (reset 1000), and the AND of
// the three. Sustained rate is one byte per clock while verdicts are popped; the
// limit is the decode step in the back end, which consumes one queued byte per cycle.
// A verdict reaches the rsp_ ports once the final byte has passed the input queue
// and the verdict register. The input queue (QUEUE_DEPTH entries) absorbs stalls on
// the result side, and bytes that produce no verdict keep flowing while a verdict
// waits to be popped. Write csr_wdata only while no text is in flight.
module utf8_nonblank_validator
   import uv_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_well_formed,
   output logic        rsp_not_blank,
   output logic        rsp_within_length,
   output logic        rsp_accepted,
   input  logic        csr_write,
   input  logic [10:0] csr_wdata
);

   logic     item_valid;
   item_type item;
   logic     item_take;

   uv_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_data_byte (req_data_byte),
      .req_last      (req_last),
      .item_valid    (item_valid),
      .item          (item),
      .item_take     (item_take)
   );

   uv_back u_back (
      .clock             (clock),
      .reset             (reset),
      .item_valid        (item_valid),
      .item              (item),
      .item_take         (item_take),
      .csr_write         (csr_write),
      .csr_wdata         (csr_wdata),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_well_formed   (rsp_well_formed),
      .rsp_not_blank     (rsp_not_blank),
      .rsp_within_length (rsp_within_length),
      .rsp_accepted      (rsp_accepted)
   );

endmodule

### hw/rtl/uv_front.sv
// Front end: classifies each incoming byte and queues it for the decoder.
module uv_front
   import uv_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_data_byte,
   input  logic       req_last,
   output logic       item_valid,
   output item_type   item,
   input  logic       item_take
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   item_type          mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   item_type          class_item;
   logic              push_ok;

   always_comb begin
      class_item.last  = req_last;
      class_item.space = is_space({13'd0, req_data_byte});
      class_item.bits  = req_data_byte[5:0];
      if (req_data_byte inside {[8'h00:8'h7F]}) begin
         class_item.kind = KIND_ASCII;
      end else if (req_data_byte inside {[8'h80:8'hBF]}) begin
         class_item.kind = KIND_CONT;
      end else if (req_data_byte inside {[8'hC2:8'hDF]}) begin
         class_item.kind = KIND_LEAD2;
         class_item.bits = {1'b0, req_data_byte[4:0]};
      end else if (req_data_byte inside {[8'hE0:8'hEF]}) begin
         class_item.kind = KIND_LEAD3;
         class_item.bits = {2'b0, req_data_byte[3:0]};
      end else if (req_data_byte inside {[8'hF0:8'hF4]}) begin
         class_item.kind = KIND_LEAD4;
         class_item.bits = {3'b0, req_data_byte[2:0]};
      end else begin
         class_item.kind = KIND_BAD;
      end
   end

   assign req_full   = (count_ff == CW'(QUEUE_DEPTH));
   assign push_ok    = req_push && !req_full;
   assign item_valid = (count_ff != '0);
   assign item       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (item_take) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push_ok, item_take})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= class_item;
      end
   end

endmodule

### hw/rtl/uv_back.sv
// Back end: UTF-8 decode state, byte count, length limit and verdict register.
module uv_back
   import uv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        item_valid,
   input  item_type    item,
   output logic        item_take,
   input  logic        csr_write,
   input  logic [10:0] csr_wdata,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_well_formed,
   output logic        rsp_not_blank,
   output logic        rsp_within_length,
   output logic        rsp_accepted
);
   `include "utf8_nonblank_validator_macros.svh"

   logic [10:0] max_ff;
   logic [1:0]  pend_ff, pend_in;
   logic [20:0] cp_ff, cp_in;
   logic [1:0]  cls_ff, cls_in;
   logic        err_ff, err_in;
   logic        vis_ff, vis_in;
   logic [10:0] cnt_ff, cnt_in;
   logic        rsp_valid_ff;
   logic        wf_ff, nb_ff, wl_ff;
   logic        wf_in, wl_in;
   logic [20:0] cp_ext;

   assign item_take = item_valid && (!item.last || !rsp_valid_ff || rsp_pop);

   always_comb begin
      pend_in = pend_ff;
      cp_in   = cp_ff;
      cls_in  = cls_ff;
      err_in  = err_ff;
      vis_in  = vis_ff;
      cnt_in  = (cnt_ff == COUNT_MAX) ? cnt_ff : cnt_ff + 11'd1;
      cp_ext  = {cp_ff[14:0], item.bits};
      if (!err_ff) begin
         if (pend_ff == 2'd0) begin
            case (item.kind)
               KIND_ASCII: begin
                  if (!item.space) vis_in = 1'b1;
               end
               KIND_LEAD2: begin
                  pend_in = 2'd1;
                  cp_in   = {15'd0, item.bits};
                  cls_in  = CLS_2B;
               end
               KIND_LEAD3: begin
                  pend_in = 2'd2;
                  cp_in   = {15'd0, item.bits};
                  cls_in  = CLS_3B;
               end
               KIND_LEAD4: begin
                  pend_in = 2'd3;
                  cp_in   = {15'd0, item.bits};
                  cls_in  = CLS_4B;
               end
               default: err_in = 1'b1;
            endcase
         end else if (item.kind != KIND_CONT) begin
            err_in = 1'b1;
         end else begin
            cp_in   = cp_ext;
            pend_in = pend_ff - 2'd1;
            if (pend_ff == 2'd1) begin
               if (cp_ext < floor_of(cls_ff) || cp_ext > CP_MAX ||
                   (cp_ext >= SURR_LO && cp_ext <= SURR_HI)) begin
                  err_in = 1'b1;
               end else if (!is_space(cp_ext)) begin
                  vis_in = 1'b1;
               end
            end
         end
      end
      wf_in = !err_in && (pend_in == 2'd0);
      wl_in = (cnt_in != COUNT_MAX) && (cnt_in <= max_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= MAX_BYTES_RESET;
      end else if (csr_write) begin
         max_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         cp_ff   <= '0;
         cls_ff  <= '0;
         err_ff  <= 1'b0;
         vis_ff  <= 1'b0;
         cnt_ff  <= '0;
      end else if (item_take) begin
         if (item.last) begin
            pend_ff <= '0;
            cp_ff   <= '0;
            cls_ff  <= '0;
            err_ff  <= 1'b0;
            vis_ff  <= 1'b0;
            cnt_ff  <= '0;
         end else begin
            pend_ff <= pend_in;
            cp_ff   <= cp_in;
            cls_ff  <= cls_in;
            err_ff  <= err_in;
            vis_ff  <= vis_in;
            cnt_ff  <= cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (item_take && item.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (item_take && item.last) begin
         wf_ff <= wf_in;
         nb_ff <= vis_in;
         wl_ff <= wl_in;
      end
   end

   assign rsp_empty         = !rsp_valid_ff;
   assign rsp_well_formed   = wf_ff;
   assign rsp_not_blank     = nb_ff;
   assign rsp_within_length = wl_ff;
   assign rsp_accepted      = wf_ff && nb_ff && wl_ff;

   `UV_ASSERT_IMPLY(a_no_overwrite, item_take && item.last, !rsp_valid_ff || rsp_pop, "verdict overwritten before transfer")
   `UV_ASSERT_NEXT(a_text_clears, item_take && item.last, cnt_ff == '0 && pend_ff == '0 && !err_ff && !vis_ff, "state not cleared after final byte")
   `UV_ASSERT_NEXT(a_error_sticks, err_ff && !(item_take && item.last), err_ff, "error flag dropped within a text")
   `UV_ASSERT_NEXT(a_count_saturates, cnt_ff == COUNT_MAX && !(item_take && item.last), cnt_ff == COUNT_MAX, "byte count left saturation")

endmodule
